// ===== rtl/sat_pkg.sv =====
// Shared constants, codes and the controller/datapath command struct for the
// segment address translator. No dependencies.
package sat_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  localparam int ADDR_W      = 32;
  localparam int ID_W        = 8;
  localparam int INDEX_W     = 4;
  localparam int STATUS_W    = 2;

  // radix-2 restoring divider: one quotient bit per step
  localparam int DIV_STEPS   = ADDR_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  // base and size share one table word
  localparam int ENTRY_W     = 2 * ADDR_W;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FAULT     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  localparam logic ACT_WRITE     = 1'b0;
  localparam logic ACT_TRANSLATE = 1'b1;

  typedef struct packed {
    logic capture;      // latch input item, seed divider
    logic table_write;  // store latched slot contents
    logic div_step;     // one divider iteration
    logic match;        // compare quotient against ids, register hit
    logic ram_read;     // read base/size of hit slot
    logic load_result;  // load output register
  } sat_cmd_t;

endpackage

// ===== rtl/sat_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/sat_ctrl.sv =====
// Sequencing state machine for the segment address translator.
// Depends on sat_pkg.
module sat_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              action,
  output logic              req_stall,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output sat_pkg::sat_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_WRITE  = 6'b000010,
    S_DIV    = 6'b000100,
    S_MATCH  = 6'b001000,
    S_READ   = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t                        state, state_next;
  logic [sat_pkg::DIV_CNT_W-1:0] div_count, div_count_next;
  logic                          rsp_valid_next;
  logic                          accept;
  logic                          out_free;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    state_next     = state;
    div_count_next = div_count;
    cmd            = '0;
    rsp_valid_next = rsp_valid && rsp_stall;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.capture    = 1'b1;
          div_count_next = '0;
          state_next     = (action == sat_pkg::ACT_WRITE) ? S_WRITE : S_DIV;
        end
      end
      S_WRITE: begin
        cmd.table_write = 1'b1;
        state_next      = S_FINISH;
      end
      S_DIV: begin
        cmd.div_step   = 1'b1;
        div_count_next = div_count + 1'b1;
        if (div_count == sat_pkg::DIV_CNT_W'(sat_pkg::DIV_STEPS - 1)) begin
          state_next = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.match  = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.ram_read = 1'b1;
        state_next   = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_result = 1'b1;
          rsp_valid_next  = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_count <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      div_count <= div_count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

// ===== rtl/sat_dpath.sv =====
// Datapath: item capture, restoring divider, id match, segment table and
// output register. Depends on sat_pkg and sat_ram.
module sat_dpath (
  input  logic                           clk,
  input  logic                           rst,
  input  sat_pkg::sat_cmd_t              cmd,
  input  logic                           cfg_wr,
  input  logic [sat_pkg::ADDR_W-1:0]     cfg_data,
  input  logic                           action,
  input  logic [sat_pkg::INDEX_W-1:0]    slot_index,
  input  logic                           slot_valid,
  input  logic [sat_pkg::ID_W-1:0]       segment_id,
  input  logic [sat_pkg::ADDR_W-1:0]     segment_base,
  input  logic [sat_pkg::ADDR_W-1:0]     segment_length,
  input  logic [sat_pkg::ADDR_W-1:0]     logical_address,
  output logic [sat_pkg::ADDR_W-1:0]     physical_address,
  output logic [sat_pkg::ADDR_W-1:0]     segment_number,
  output logic [sat_pkg::ADDR_W-1:0]     segment_offset,
  output logic [sat_pkg::STATUS_W-1:0]   status
);

  localparam int AW = sat_pkg::ADDR_W;
  localparam int SW = sat_pkg::SLOT_W;

  logic [AW-1:0]               divisor;

  // latched item
  logic                        action_q;
  logic [sat_pkg::INDEX_W-1:0] slot_index_q;
  logic                        slot_valid_q;
  logic [sat_pkg::ID_W-1:0]    segment_id_q;
  logic [AW-1:0]               base_q;
  logic [AW-1:0]               length_q;

  // divider: quo starts as the dividend and shifts quotient bits in
  logic [AW-1:0]               rem;
  logic [AW-1:0]               quo;
  logic [AW:0]                 trial;
  logic [AW:0]                 trial_diff;
  logic                        trial_ge;

  logic                        entry_valid [sat_pkg::TABLE_SLOTS];
  logic [sat_pkg::ID_W-1:0]    entry_id    [sat_pkg::TABLE_SLOTS];

  logic                        slot_ok;
  logic [SW-1:0]               wr_slot;
  logic                        hit_found;
  logic [SW-1:0]               hit_slot;
  logic                        found_q;
  logic [SW-1:0]               hit_q;
  logic [sat_pkg::ENTRY_W-1:0] entry_rd;
  logic [AW-1:0]               entry_base_rd;
  logic [AW-1:0]               entry_size_rd;
  logic [AW-1:0]               sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      divisor <= AW'(1);
    end else if (cfg_wr) begin
      divisor <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_q     <= action;
      slot_index_q <= slot_index;
      slot_valid_q <= slot_valid;
      segment_id_q <= segment_id;
      base_q       <= segment_base;
      length_q     <= segment_length;
    end
  end

  // divisor of zero gives all-ones quotient and remainder equal to dividend
  assign trial      = {rem, quo[AW-1]};
  assign trial_ge   = (trial >= {1'b0, divisor});
  assign trial_diff = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rem <= '0;
      quo <= logical_address;
    end else if (cmd.div_step) begin
      rem <= trial_ge ? trial_diff[AW-1:0] : trial[AW-1:0];
      quo <= {quo[AW-2:0], trial_ge};
    end
  end

  // table write; slots past the table are dropped
  assign slot_ok = (32'(slot_index_q) < 32'(sat_pkg::TABLE_SLOTS));
  assign wr_slot = SW'(slot_index_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sat_pkg::TABLE_SLOTS; i++) begin
        entry_valid[i] <= 1'b0;
      end
    end else if (cmd.table_write && slot_ok) begin
      entry_valid[wr_slot] <= slot_valid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.table_write && slot_ok) begin
      entry_id[wr_slot] <= segment_id_q;
    end
  end

  // id match: lowest valid slot wins; numbers above the id range never match
  always_comb begin
    hit_found = 1'b0;
    hit_slot  = '0;
    for (int i = sat_pkg::TABLE_SLOTS - 1; i >= 0; i--) begin
      if (entry_valid[i] && (quo[AW-1:sat_pkg::ID_W] == '0) &&
          (entry_id[i] == quo[sat_pkg::ID_W-1:0])) begin
        hit_found = 1'b1;
        hit_slot  = SW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match) begin
      found_q <= hit_found;
      hit_q   <= hit_slot;
    end
  end

  sat_ram #(
    .WIDTH (sat_pkg::ENTRY_W),
    .DEPTH (sat_pkg::TABLE_SLOTS)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (cmd.table_write && slot_ok),
    .wr_addr (wr_slot),
    .wr_data ({base_q, length_q}),
    .rd_en   (cmd.ram_read),
    .rd_addr (hit_q),
    .rd_data (entry_rd)
  );

  assign entry_base_rd = entry_rd[sat_pkg::ENTRY_W-1:AW];
  assign entry_size_rd = entry_rd[AW-1:0];
  assign sum           = entry_base_rd + rem;

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      if (action_q == sat_pkg::ACT_WRITE) begin
        physical_address <= '0;
        segment_number   <= '0;
        segment_offset   <= '0;
        status           <= sat_pkg::ST_OK;
      end else begin
        segment_number <= quo;
        segment_offset <= rem;
        if (!found_q) begin
          physical_address <= '0;
          status           <= sat_pkg::ST_NOT_FOUND;
        end else if (rem >= entry_size_rd) begin
          physical_address <= '0;
          status           <= sat_pkg::ST_FAULT;
        end else begin
          physical_address <= sum;
          status           <= sat_pkg::ST_OK;
        end
      end
    end
  end

endmodule

// ===== rtl/segment_address_translator.sv =====
// Segment address translator: table of segments plus logical-to-physical
// translation. A translate item passes the 32 radix-2 divider steps, the
// match, the table read and the load; a table write passes the write and the
// load. The load waits while a held result is stalled. One item is in work
// at a time, and the next transfer is taken only after the load. rst clears
// the valid marks, the divisor (to 1) and all control state.
// Depends on sat_pkg, sat_ctrl, sat_dpath and sat_ram.
module segment_address_translator (
  input  logic                           clk,
  input  logic                           rst,

  // configuration: max segment size, always writable
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sat_pkg::ADDR_W-1:0]     cfg_data,

  // request channel
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic                           action,
  input  logic [sat_pkg::INDEX_W-1:0]    slot_index,
  input  logic                           slot_valid,
  input  logic [sat_pkg::ID_W-1:0]       segment_id,
  input  logic [sat_pkg::ADDR_W-1:0]     segment_base,
  input  logic [sat_pkg::ADDR_W-1:0]     segment_length,
  input  logic [sat_pkg::ADDR_W-1:0]     logical_address,

  // response channel
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic [sat_pkg::ADDR_W-1:0]     physical_address,
  output logic [sat_pkg::ADDR_W-1:0]     segment_number,
  output logic [sat_pkg::ADDR_W-1:0]     segment_offset,
  output logic [sat_pkg::STATUS_W-1:0]   status
);

  sat_pkg::sat_cmd_t cmd;

  // user must let the register change only between items (not enforced here); no back-pressure
  assign cfg_ready = 1'b1;

  // controller: request acceptance, divider count, output valid
  sat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .action    (action),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  // datapath: divider, table, match and output register; the output
  // register holds a finished result while the next item is taken in
  sat_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cfg_wr           (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .action           (action),
    .slot_index       (slot_index),
    .slot_valid       (slot_valid),
    .segment_id       (segment_id),
    .segment_base     (segment_base),
    .segment_length   (segment_length),
    .logical_address  (logical_address),
    .physical_address (physical_address),
    .segment_number   (segment_number),
    .segment_offset   (segment_offset),
    .status           (status)
  );

endmodule
